[rtl/core/biquad_pkg.sv]
// Shared definitions for the cascaded biquad IIR filter: default sizes,
// register indexes, coefficient slots and the controller-to-datapath command.
// No dependencies.
package biquad_pkg;

  localparam int MAX_SECTIONS_DEF = 8;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 32;

  // Internal values carry this many fraction bits.
  localparam int FRAC_BITS = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SECTIONS_W  = 4;
  localparam int COEF_IDX_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_SECTIONS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_INDEX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_VALUE = 2'd2;

  localparam int SLOTS_PER_SECTION = 6;

  localparam logic [2:0] SLOT_GAIN = 3'd0;
  localparam logic [2:0] SLOT_B0   = 3'd1;
  localparam logic [2:0] SLOT_B1   = 3'd2;
  localparam logic [2:0] SLOT_B2   = 3'd3;
  localparam logic [2:0] SLOT_A1   = 3'd4;
  localparam logic [2:0] SLOT_A2   = 3'd5;

  localparam logic [2:0] OPD_X0 = 3'd0;
  localparam logic [2:0] OPD_X1 = 3'd1;
  localparam logic [2:0] OPD_X2 = 3'd2;
  localparam logic [2:0] OPD_F  = 3'd3;
  localparam logic [2:0] OPD_Y1 = 3'd4;
  localparam logic [2:0] OPD_Y2 = 3'd5;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  typedef struct packed {
    logic       sample_load;
    logic       row_rd;
    logic       row0_wr;
    logic       y_wr;
    logic       coef_rd;
    logic [2:0] coef_slot;
    logic       mul_en;
    logic [2:0] opd_sel;
    logic [1:0] acc_op;
    logic       f_load;
    logic       out_load;
  } dp_cmd_t;

endpackage

[rtl/core/cascaded_biquad_iir_filter.sv]
// Top level of the cascaded biquad IIR filter in direct form I.
// Instantiates biquad_ctrl and biquad_dp; depends on biquad_pkg.
//
//   Channel  Ports                                   Direction  Transfer
//   in       in_valid, in_ready, in_sample            input      one sample
//   out      out_valid, out_ready, out_filtered,      output     one result
//            out_saturated
//   cfg      cfg_valid, cfg_ready, cfg_index,         input      one register write
//            cfg_data
//
// Each sample passes through all n effective sections, where one shared multiplier
// computes six products per section. A new sample is accepted only after the previous
// result has been loaded into the output register.
// The result stays in the output register until its transfer; the controller waits to
// load the next result while it is still held. Configuration writes are always accepted.
// Reset is synchronous and clears the delay rows and coefficients through valid bits.
module cascaded_biquad_iir_filter #(
  parameter int MAX_SECTIONS = biquad_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = biquad_pkg::COEF_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_filtered,
  output logic                               out_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [biquad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [biquad_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RowAw = $clog2(MAX_SECTIONS + 1);

  biquad_pkg::dp_cmd_t cmd;
  logic [RowAw-1:0]    row_rd_addr;
  logic [RowAw-1:0]    row_wr_addr;
  logic [RowAw-1:0]    coef_sec;
  logic [RowAw-1:0]    eff_sections;

  assign cfg_ready = 1'b1;

  biquad_ctrl #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .eff_sections (eff_sections),
    .cmd          (cmd),
    .row_rd_addr  (row_rd_addr),
    .row_wr_addr  (row_wr_addr),
    .coef_sec     (coef_sec)
  );

  biquad_dp #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_sample     (in_sample),
    .cmd           (cmd),
    .row_rd_addr   (row_rd_addr),
    .row_wr_addr   (row_wr_addr),
    .coef_sec      (coef_sec),
    .eff_sections  (eff_sections),
    .out_filtered  (out_filtered),
    .out_saturated (out_saturated)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before its transfer");

  a_row_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.y_wr || cmd.row0_wr) |-> !in_ready)
    else $error("delay row written while idle");

  a_single_row_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.y_wr && cmd.row0_wr))
    else $error("two delay row writes in one cycle");
`endif

endmodule

[rtl/core/biquad_dp.sv]
// Datapath of the cascaded biquad IIR filter: configuration registers,
// coefficient and delay row memories, shared multiply-accumulate unit, output register.
// Depends on biquad_pkg.
module biquad_dp #(
  parameter int MAX_SECTIONS = biquad_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = biquad_pkg::COEF_WIDTH_DEF,
  localparam int RowAw       = $clog2(MAX_SECTIONS + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  input  logic [biquad_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [biquad_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample,
  input  biquad_pkg::dp_cmd_t                    cmd,
  input  logic [RowAw-1:0]                       row_rd_addr,
  input  logic [RowAw-1:0]                       row_wr_addr,
  input  logic [RowAw-1:0]                       coef_sec,
  output logic [RowAw-1:0]                       eff_sections,
  output logic signed [SAMPLE_WIDTH-1:0]         out_filtered,
  output logic                                   out_saturated
);

  localparam int IntW      = SAMPLE_WIDTH + biquad_pkg::FRAC_BITS;
  localparam int CoefFrac  = COEF_WIDTH - 3;
  localparam int ProdW     = IntW + COEF_WIDTH;
  localparam int RndW      = ProdW - CoefFrac;
  localparam int AccW      = IntW + 6;
  localparam int Rows      = MAX_SECTIONS + 1;
  localparam int CoefSlots = biquad_pkg::SLOTS_PER_SECTION * MAX_SECTIONS;
  localparam int CoefAw    = $clog2(CoefSlots);

  localparam logic signed [ProdW-1:0] ProdHalf = ProdW'(64'd1 << (CoefFrac - 1));
  localparam logic signed [AccW-1:0] AccMax =
    {{(AccW - IntW + 1){1'b0}}, {(IntW - 1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin =
    {{(AccW - IntW + 1){1'b1}}, {(IntW - 1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH:0] OutMax = {2'b00, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH:0] OutMin = {2'b11, {(SAMPLE_WIDTH - 1){1'b0}}};
  localparam logic signed [IntW:0] OutHalf = (IntW + 1)'(1 << (biquad_pkg::FRAC_BITS - 1));

  logic [biquad_pkg::SECTIONS_W-1:0] sections_r;
  logic [biquad_pkg::COEF_IDX_W-1:0] coef_index_r;

  logic [COEF_WIDTH-1:0] coef_mem [CoefSlots];
  logic [CoefSlots-1:0]  coef_vld_r;
  logic signed [COEF_WIDTH-1:0] coef_q_r;
  logic                  coef_we;
  logic [CoefAw-1:0]     coef_waddr;
  logic [CoefAw-1:0]     coef_raddr;

  logic [3*IntW-1:0] row_mem [Rows];
  logic [Rows-1:0]   row_vld_r;
  logic [3*IntW-1:0] row_q_r;
  logic [3*IntW-1:0] xt_r;
  logic [3*IntW-1:0] row_new;
  logic              row_we;

  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic signed [IntW-1:0]         x_scaled;
  logic signed [IntW-1:0]         opd;
  logic signed [ProdW-1:0]        p_r;
  logic signed [ProdW-1:0]        p_half;
  logic signed [RndW-1:0]         p_rnd;
  logic signed [AccW-1:0]         acc_r;
  logic signed [AccW-1:0]         acc_nxt;
  logic signed [IntW-1:0]         acc_sat;
  logic                           acc_hi;
  logic                           acc_lo;
  logic signed [IntW-1:0]         f_r;
  logic                           clip_r;

  logic signed [IntW:0]           y_sum;
  logic signed [SAMPLE_WIDTH:0]   y_out;
  logic                           out_hi;
  logic                           out_lo;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered_r;
  logic                           out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sections_r   <= biquad_pkg::SECTIONS_W'(1);
      coef_index_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        biquad_pkg::CFG_SECTIONS:   sections_r   <= cfg_data[biquad_pkg::SECTIONS_W-1:0];
        biquad_pkg::CFG_COEF_INDEX: coef_index_r <= cfg_data[biquad_pkg::COEF_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sections_r == '0) begin
      eff_sections = RowAw'(1);
    end else if (32'(sections_r) > 32'(MAX_SECTIONS)) begin
      eff_sections = RowAw'(MAX_SECTIONS);
    end else begin
      eff_sections = RowAw'(sections_r);
    end
  end

  assign coef_we = cfg_valid && (cfg_index == biquad_pkg::CFG_COEF_VALUE) &&
                   (32'(coef_index_r) < 32'(CoefSlots));
  assign coef_waddr = CoefAw'(coef_index_r);
  assign coef_raddr = CoefAw'(32'(coef_sec) * 32'(biquad_pkg::SLOTS_PER_SECTION) +
                              32'(cmd.coef_slot));

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= cfg_data[COEF_WIDTH-1:0];
    end
    if (cmd.coef_rd) begin
      coef_q_r <= coef_vld_r[coef_raddr] ? coef_mem[coef_raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_we) begin
      coef_vld_r[coef_waddr] <= 1'b1;
    end
  end

  assign x_scaled = {sample_r, {biquad_pkg::FRAC_BITS{1'b0}}};
  assign row_we   = cmd.row0_wr || cmd.y_wr;
  assign row_new  = {row_q_r[2*IntW-1:0], (cmd.row0_wr ? x_scaled : acc_sat)};

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wr_addr] <= row_new;
      xt_r                 <= row_new;
    end
    if (cmd.row_rd) begin
      row_q_r <= row_vld_r[row_rd_addr] ? row_mem[row_rd_addr] : '0;
    end
    if (cmd.sample_load) begin
      sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (row_we) begin
      row_vld_r[row_wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    case (cmd.opd_sel)
      biquad_pkg::OPD_X1: opd = xt_r[2*IntW-1:IntW];
      biquad_pkg::OPD_X2: opd = xt_r[3*IntW-1:2*IntW];
      biquad_pkg::OPD_F:  opd = f_r;
      biquad_pkg::OPD_Y1: opd = row_q_r[IntW-1:0];
      biquad_pkg::OPD_Y2: opd = row_q_r[2*IntW-1:IntW];
      default:            opd = xt_r[IntW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r <= coef_q_r * opd;
    end
  end

  assign p_half = p_r + ProdHalf;
  assign p_rnd  = p_half[ProdW-1:CoefFrac];

  always_comb begin
    case (cmd.acc_op)
      biquad_pkg::ACC_LOAD: acc_nxt = AccW'(p_rnd);
      biquad_pkg::ACC_ADD:  acc_nxt = acc_r + AccW'(p_rnd);
      biquad_pkg::ACC_SUB:  acc_nxt = acc_r - AccW'(p_rnd);
      default:              acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.f_load) begin
      f_r <= acc_sat;
    end
  end

  assign acc_hi  = acc_r > AccMax;
  assign acc_lo  = acc_r < AccMin;
  assign acc_sat = acc_hi ? AccMax[IntW-1:0] : (acc_lo ? AccMin[IntW-1:0] : acc_r[IntW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
    end else if (cmd.sample_load) begin
      clip_r <= 1'b0;
    end else if ((cmd.f_load || cmd.y_wr) && (acc_hi || acc_lo)) begin
      clip_r <= 1'b1;
    end
  end

  assign y_sum  = {xt_r[IntW-1], xt_r[IntW-1:0]} + OutHalf;
  assign y_out  = y_sum[IntW:biquad_pkg::FRAC_BITS];
  assign out_hi = y_out > OutMax;
  assign out_lo = y_out < OutMin;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_filtered_r  <= out_hi ? OutMax[SAMPLE_WIDTH-1:0] :
                         (out_lo ? OutMin[SAMPLE_WIDTH-1:0] : y_out[SAMPLE_WIDTH-1:0]);
      out_saturated_r <= clip_r || out_hi || out_lo;
    end
  end

  assign out_filtered  = out_filtered_r;
  assign out_saturated = out_saturated_r;

endmodule

[rtl/core/biquad_ctrl.sv]
// Controller of the cascaded biquad IIR filter: sequences the shared
// multiply-accumulate over the sections and owns the channel handshakes.
// Depends on biquad_pkg.
module biquad_ctrl #(
  parameter int MAX_SECTIONS = biquad_pkg::MAX_SECTIONS_DEF,
  localparam int RowAw       = $clog2(MAX_SECTIONS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic [RowAw-1:0]    eff_sections,
  output biquad_pkg::dp_cmd_t cmd,
  output logic [RowAw-1:0]    row_rd_addr,
  output logic [RowAw-1:0]    row_wr_addr,
  output logic [RowAw-1:0]    coef_sec
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ROW0 = 4'd1;
  localparam logic [3:0] ST_P0   = 4'd2;
  localparam logic [3:0] ST_P1   = 4'd3;
  localparam logic [3:0] ST_P2   = 4'd4;
  localparam logic [3:0] ST_P3   = 4'd5;
  localparam logic [3:0] ST_F    = 4'd6;
  localparam logic [3:0] ST_G    = 4'd7;
  localparam logic [3:0] ST_A1   = 4'd8;
  localparam logic [3:0] ST_A2   = 4'd9;
  localparam logic [3:0] ST_A3   = 4'd10;
  localparam logic [3:0] ST_Y    = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0]       state_r;
  logic [3:0]       state_nxt;
  logic [RowAw-1:0] sec_r;
  logic [RowAw-1:0] sec_nxt;
  logic [RowAw-1:0] sec_inc;
  logic             out_valid_r;
  logic             out_valid_nxt;

  assign sec_inc = RowAw'(32'(sec_r) + 32'd1);

  always_comb begin
    state_nxt   = state_r;
    sec_nxt     = sec_r;
    cmd         = '0;
    in_ready    = 1'b0;
    row_rd_addr = '0;
    row_wr_addr = sec_inc;
    coef_sec    = sec_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.sample_load = 1'b1;
          cmd.row_rd      = 1'b1;
          sec_nxt         = '0;
          state_nxt       = ST_ROW0;
        end
      end
      ST_ROW0: begin
        cmd.row0_wr   = 1'b1;
        row_wr_addr   = '0;
        cmd.row_rd    = 1'b1;
        row_rd_addr   = RowAw'(1);
        cmd.coef_rd   = 1'b1;
        cmd.coef_slot = biquad_pkg::SLOT_B0;
        state_nxt     = ST_P0;
      end
      ST_P0: begin
        cmd.mul_en    = 1'b1;
        cmd.opd_sel   = biquad_pkg::OPD_X0;
        cmd.coef_rd   = 1'b1;
        cmd.coef_slot = biquad_pkg::SLOT_B1;
        state_nxt     = ST_P1;
      end
      ST_P1: begin
        cmd.mul_en    = 1'b1;
        cmd.opd_sel   = biquad_pkg::OPD_X1;
        cmd.acc_op    = biquad_pkg::ACC_LOAD;
        cmd.coef_rd   = 1'b1;
        cmd.coef_slot = biquad_pkg::SLOT_B2;
        state_nxt     = ST_P2;
      end
      ST_P2: begin
        cmd.mul_en    = 1'b1;
        cmd.opd_sel   = biquad_pkg::OPD_X2;
        cmd.acc_op    = biquad_pkg::ACC_ADD;
        cmd.coef_rd   = 1'b1;
        cmd.coef_slot = biquad_pkg::SLOT_GAIN;
        state_nxt     = ST_P3;
      end
      ST_P3: begin
        cmd.acc_op = biquad_pkg::ACC_ADD;
        state_nxt  = ST_F;
      end
      ST_F: begin
        cmd.f_load = 1'b1;
        state_nxt  = ST_G;
      end
      ST_G: begin
        cmd.mul_en    = 1'b1;
        cmd.opd_sel   = biquad_pkg::OPD_F;
        cmd.coef_rd   = 1'b1;
        cmd.coef_slot = biquad_pkg::SLOT_A1;
        state_nxt     = ST_A1;
      end
      ST_A1: begin
        cmd.mul_en    = 1'b1;
        cmd.opd_sel   = biquad_pkg::OPD_Y1;
        cmd.acc_op    = biquad_pkg::ACC_LOAD;
        cmd.coef_rd   = 1'b1;
        cmd.coef_slot = biquad_pkg::SLOT_A2;
        state_nxt     = ST_A2;
      end
      ST_A2: begin
        cmd.mul_en  = 1'b1;
        cmd.opd_sel = biquad_pkg::OPD_Y2;
        cmd.acc_op  = biquad_pkg::ACC_SUB;
        state_nxt   = ST_A3;
      end
      ST_A3: begin
        cmd.acc_op = biquad_pkg::ACC_SUB;
        state_nxt  = ST_Y;
      end
      ST_Y: begin
        cmd.y_wr = 1'b1;
        if (sec_inc == eff_sections) begin
          state_nxt = ST_OUT;
        end else begin
          sec_nxt       = sec_inc;
          cmd.row_rd    = 1'b1;
          row_rd_addr   = RowAw'(32'(sec_r) + 32'd2);
          cmd.coef_rd   = 1'b1;
          cmd.coef_slot = biquad_pkg::SLOT_B0;
          coef_sec      = sec_inc;
          state_nxt     = ST_P0;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
